>>> src/mbml_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbml_pkg;

   // fixed geometry of a table and of a sector
   localparam int TABLE_WORDS  = 128;
   localparam int SECTOR_BYTES = 512;
   localparam int WORD_W       = $clog2(TABLE_WORDS);
   localparam int PAGE_SHIFT   = $clog2(SECTOR_BYTES);
   localparam int OFFSET_W     = 31;
   localparam int PS_W         = OFFSET_W - PAGE_SHIFT;
   localparam int VALUE_W      = 32;

   localparam int DIRECT_ENTRIES_DEF = 123;
   localparam int STORE_SECTORS_DEF  = 256;

   localparam logic [1:0] MODE_LOOKUP    = 2'd0;
   localparam logic [1:0] MODE_DIRECT_WR = 2'd1;
   localparam logic [1:0] MODE_STORE_WR  = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BEYOND = 2'd1;
   localparam logic [1:0] ST_BADPTR = 2'd2;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE = 1'b1;

   typedef struct packed {
      logic [1:0]          mode;
      logic [OFFSET_W-1:0] byte_offset;
      logic [7:0]          table_sector;
      logic [6:0]          entry_index;
      logic [VALUE_W-1:0]  entry_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] sector;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

endpackage

`default_nettype wire

>>> src/multilevel_block_map_lookup.sv
`timescale 1ns / 1ps
`default_nettype none

// Block map lookup: an item either writes a direct-map entry, writes one word of
// the table store, or turns a byte offset into a device sector through the direct
// map, the single-indirect table or the two-level double-indirect table. The block
// works on one item at a time. Writes, the unused mode, offsets beyond the map and
// bad table registers go straight to the result; direct and single-indirect lookups
// first read one memory word, double-indirect lookups the top-table word and then
// the leaf word, ending after the top-table read when that word points outside the
// store. The table store is single-port with registered reads, like the direct map,
// so the leaf read must wait for the top-table word. The direct map comes out of
// reset all zero at once through per-entry valid bits; there is no clearing pass.
// Table store words must be written before a lookup reads them. A result waiting on
// a stalled output does not block the next item from being taken.
module multilevel_block_map_lookup #(
   parameter int DIRECT_ENTRIES = mbml_pkg::DIRECT_ENTRIES_DEF,
   parameter int STORE_SECTORS  = mbml_pkg::STORE_SECTORS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mbml_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mbml_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [mbml_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mbml_pkg::VALUE_W-1:0]   csr_wdata
);
   import mbml_pkg::*;

   localparam int DIR_W  = (DIRECT_ENTRIES > 1) ? $clog2(DIRECT_ENTRIES) : 1;
   localparam int ADDR_W = $clog2(STORE_SECTORS) + WORD_W;

   logic [VALUE_W-1:0] single_sector_ff, single_sector_in;
   logic [VALUE_W-1:0] double_sector_ff, double_sector_in;

   mem_cmd_type        dir_cmd;
   logic [DIR_W-1:0]   dir_idx;
   logic [VALUE_W-1:0] dir_wdata;
   logic [VALUE_W-1:0] dir_rdata;
   mem_cmd_type        store_cmd;
   logic [ADDR_W-1:0]  store_addr;
   logic [VALUE_W-1:0] store_wdata;
   logic [VALUE_W-1:0] store_rdata;

   always_comb begin
      single_sector_in = single_sector_ff;
      double_sector_in = double_sector_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SINGLE: single_sector_in = csr_wdata;
            CSR_DOUBLE: double_sector_in = csr_wdata;
            default:    single_sector_in = single_sector_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         single_sector_ff <= '0;
         double_sector_ff <= '0;
      end else begin
         single_sector_ff <= single_sector_in;
         double_sector_ff <= double_sector_in;
      end
   end

   mbml_ctrl #(
      .DIRECT_ENTRIES (DIRECT_ENTRIES),
      .STORE_SECTORS  (STORE_SECTORS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .single_sector (single_sector_ff),
      .double_sector (double_sector_ff),
      .dir_cmd       (dir_cmd),
      .dir_idx       (dir_idx),
      .dir_wdata     (dir_wdata),
      .dir_rdata     (dir_rdata),
      .store_cmd     (store_cmd),
      .store_addr    (store_addr),
      .store_wdata   (store_wdata),
      .store_rdata   (store_rdata)
   );

   mbml_direct_map #(
      .DIRECT_ENTRIES (DIRECT_ENTRIES)
   ) u_direct_map (
      .clock (clock),
      .reset (reset),
      .cmd   (dir_cmd),
      .idx   (dir_idx),
      .wdata (dir_wdata),
      .rdata (dir_rdata)
   );

   mbml_table_store #(
      .STORE_SECTORS (STORE_SECTORS)
   ) u_table_store (
      .clock (clock),
      .cmd   (store_cmd),
      .addr  (store_addr),
      .wdata (store_wdata),
      .rdata (store_rdata)
   );

`ifndef SYNTH
   a_store_single_port: assert property (@(posedge clock) disable iff (reset)
      !(store_cmd.wr_en && store_cmd.rd_en))
      else $error("table store read and written in one cycle");

   a_dir_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      dir_cmd.wr_en |-> (req_valid && !req_stall))
      else $error("direct map written without an accepted item");

   a_busy_after_accept: assert property (@(posedge clock)
      (req_valid && !req_stall && !reset) |=> req_stall)
      else $error("second item taken while one is in flight");

   a_busy_after_store_read: assert property (@(posedge clock)
      (store_cmd.rd_en && !reset) |=> req_stall)
      else $error("item taken while table store read data is pending");
`endif

endmodule

`default_nettype wire

>>> src/mbml_direct_map.sv
`timescale 1ns / 1ps
`default_nettype none

module mbml_direct_map #(
   parameter int DIRECT_ENTRIES = mbml_pkg::DIRECT_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mbml_pkg::mem_cmd_type       cmd,
   input  logic [((DIRECT_ENTRIES > 1) ? $clog2(DIRECT_ENTRIES) : 1)-1:0] idx,
   input  logic [mbml_pkg::VALUE_W-1:0] wdata,
   output logic [mbml_pkg::VALUE_W-1:0] rdata
);
   import mbml_pkg::*;

   logic [VALUE_W-1:0]        mem [DIRECT_ENTRIES];
   logic [DIRECT_ENTRIES-1:0] valid_ff;
   logic [VALUE_W-1:0]        rdata_ff;
   logic                      hit_ff;

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[idx] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[idx];
         hit_ff   <= valid_ff[idx];
      end
   end

   assign rdata = hit_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

>>> src/mbml_table_store.sv
`timescale 1ns / 1ps
`default_nettype none

module mbml_table_store #(
   parameter int STORE_SECTORS = mbml_pkg::STORE_SECTORS_DEF
) (
   input  logic                         clock,
   input  mbml_pkg::mem_cmd_type        cmd,
   input  logic [$clog2(STORE_SECTORS)+mbml_pkg::WORD_W-1:0] addr,
   input  logic [mbml_pkg::VALUE_W-1:0] wdata,
   output logic [mbml_pkg::VALUE_W-1:0] rdata
);
   import mbml_pkg::*;

   localparam int DEPTH = STORE_SECTORS * TABLE_WORDS;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> src/mbml_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mbml_ctrl #(
   parameter int DIRECT_ENTRIES = mbml_pkg::DIRECT_ENTRIES_DEF,
   parameter int STORE_SECTORS  = mbml_pkg::STORE_SECTORS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  mbml_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output mbml_pkg::rsp_type            rsp_data,
   input  logic [mbml_pkg::VALUE_W-1:0] single_sector,
   input  logic [mbml_pkg::VALUE_W-1:0] double_sector,
   output mbml_pkg::mem_cmd_type        dir_cmd,
   output logic [((DIRECT_ENTRIES > 1) ? $clog2(DIRECT_ENTRIES) : 1)-1:0] dir_idx,
   output logic [mbml_pkg::VALUE_W-1:0] dir_wdata,
   input  logic [mbml_pkg::VALUE_W-1:0] dir_rdata,
   output mbml_pkg::mem_cmd_type        store_cmd,
   output logic [$clog2(STORE_SECTORS)+mbml_pkg::WORD_W-1:0] store_addr,
   output logic [mbml_pkg::VALUE_W-1:0] store_wdata,
   input  logic [mbml_pkg::VALUE_W-1:0] store_rdata
);
   import mbml_pkg::*;

   localparam int DIR_W = (DIRECT_ENTRIES > 1) ? $clog2(DIRECT_ENTRIES) : 1;
   localparam int SEC_W = $clog2(STORE_SECTORS);

   localparam logic [PS_W-1:0] LIM_DIR = PS_W'(DIRECT_ENTRIES);
   localparam logic [PS_W-1:0] LIM_SGL = PS_W'(DIRECT_ENTRIES + TABLE_WORDS);
   localparam logic [PS_W-1:0] LIM_DBL =
      PS_W'(DIRECT_ENTRIES + TABLE_WORDS * (TABLE_WORDS + 1));

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIR,
      S_MID,
      S_LEAF,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [WORD_W-1:0]  leaf_word_ff, leaf_word_in;
   rsp_type            pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic [PS_W-1:0]    ps;
   logic [PS_W-1:0]    rel_sgl;
   logic [PS_W-1:0]    rel_dbl;
   logic               single_bad;
   logic               double_bad;
   logic               mid_bad;

   assign req_stall  = reset || (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign ps         = req_data.byte_offset[OFFSET_W-1:PAGE_SHIFT];
   assign rel_sgl    = ps - LIM_DIR;
   assign rel_dbl    = ps - LIM_SGL;
   assign single_bad = single_sector >= VALUE_W'(STORE_SECTORS);
   assign double_bad = double_sector >= VALUE_W'(STORE_SECTORS);
   assign mid_bad    = store_rdata >= VALUE_W'(STORE_SECTORS);

   assign dir_wdata   = req_data.entry_value;
   assign store_wdata = req_data.entry_value;

   // one item at a time: every write lands before the next item can read
   always_comb begin
      state_in     = state_ff;
      leaf_word_in = leaf_word_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      dir_cmd      = '0;
      dir_idx      = ps[DIR_W-1:0];
      store_cmd    = '0;
      store_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_in  = '{sector: '0, status: ST_OK};
               state_in = S_DONE;
               case (req_data.mode)
                  MODE_LOOKUP: begin
                     if (ps < LIM_DIR) begin
                        dir_cmd.rd_en = 1'b1;
                        state_in      = S_DIR;
                     end else if (ps < LIM_SGL) begin
                        if (single_bad) begin
                           pend_in.status = ST_BADPTR;
                        end else begin
                           store_cmd.rd_en = 1'b1;
                           store_addr      = {single_sector[SEC_W-1:0],
                                              rel_sgl[WORD_W-1:0]};
                           state_in        = S_LEAF;
                        end
                     end else if (ps < LIM_DBL) begin
                        if (double_bad) begin
                           pend_in.status = ST_BADPTR;
                        end else begin
                           store_cmd.rd_en = 1'b1;
                           store_addr      = {double_sector[SEC_W-1:0],
                                              rel_dbl[2*WORD_W-1:WORD_W]};
                           leaf_word_in    = rel_dbl[WORD_W-1:0];
                           state_in        = S_MID;
                        end
                     end else begin
                        pend_in.status = ST_BEYOND;
                     end
                  end
                  MODE_DIRECT_WR: begin
                     if (32'(req_data.entry_index) < 32'(DIRECT_ENTRIES)) begin
                        dir_cmd.wr_en = 1'b1;
                        dir_idx       = DIR_W'(req_data.entry_index);
                     end
                  end
                  MODE_STORE_WR: begin
                     if (32'(req_data.table_sector) < 32'(STORE_SECTORS)) begin
                        store_cmd.wr_en = 1'b1;
                        store_addr      = {SEC_W'(req_data.table_sector),
                                           req_data.entry_index};
                     end
                  end
                  default: begin
                     pend_in.status = ST_OK;
                  end
               endcase
            end
         end
         S_DIR: begin
            pend_in  = '{sector: dir_rdata, status: ST_OK};
            state_in = S_DONE;
         end
         S_MID: begin
            // top-table word points at the leaf table
            if (mid_bad) begin
               pend_in  = '{sector: '0, status: ST_BADPTR};
               state_in = S_DONE;
            end else begin
               store_cmd.rd_en = 1'b1;
               store_addr      = {store_rdata[SEC_W-1:0], leaf_word_ff};
               state_in        = S_LEAF;
            end
         end
         S_LEAF: begin
            pend_in  = '{sector: store_rdata, status: ST_OK};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      leaf_word_ff <= leaf_word_in;
      pend_ff      <= pend_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
